/* src/ppw_pkg.sv */
// ----------------------------------------------------------------------------
// ppw_pkg
// Shared types and codes for the phrase position winnow block.
// ----------------------------------------------------------------------------
package ppw_pkg;

    // command field codes
    localparam logic CMD_FIRST = 1'b0;
    localparam logic CMD_LATER = 1'b1;

    localparam int unsigned POS_W = 32;
    localparam int unsigned OFF_W = 16;
    localparam int unsigned OUT_W = 9;

    // compare result of (anchor + offset) against a position, 33-bit exact
    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_t;

endpackage

/* src/phrase_position_winnow.sv */
// ----------------------------------------------------------------------------
// phrase_position_winnow
// Phrase frequency for one document by positional intersection of anchors.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | words
//  ---------+----------------------+-----------------------------------------
//  input    | in_valid / in_ready  | command, position, term_offset,
//           |                      | last_in_term, last_term
//  result   | out_valid / out_ready| phrase_count, anchor_overflow
//
//  A first-term word is written straight into the anchor RAM on acceptance.
//  A later-term word starts a merge walk that steps over or keeps anchors,
//  and no new word is accepted until it ends; the walk is limited by the
//  single RAM read port, one anchor per cycle through the shared match unit.
//  The word that closes the phrase passes the emit step, which loads the
//  result register, and waits there while an earlier result is still untaken.
//  No clearing pass after reset: anchors are only read below anchor_count.
//
module phrase_position_winnow #(
    parameter int unsigned MAX_ANCHORS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          command,
    input  logic [ppw_pkg::POS_W-1:0]     position,
    input  logic [ppw_pkg::OFF_W-1:0]     term_offset,
    input  logic                          last_in_term,
    input  logic                          last_term,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ppw_pkg::OUT_W-1:0]     phrase_count,
    output logic                          anchor_overflow
);

    // count width holds MAX_ANCHORS itself; address width indexes the RAM
    localparam int unsigned CW = $clog2(MAX_ANCHORS + 1);
    localparam int unsigned AW = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] anchor_count_reg, anchor_count_next;
    logic [CW-1:0] read_index_reg, read_index_next;
    logic [CW-1:0] kept_count_reg, kept_count_next;
    logic          overflow_reg, overflow_next;
    logic          term_open_reg, term_open_next;
    logic          open_cmd_reg, open_cmd_next;
    logic          phase_reg, phase_next;      // set once the walk has kept one
    logic          out_valid_reg, out_valid_next;

    // held copy of the word under work (payload, no reset)
    logic [ppw_pkg::POS_W-1:0] pos_reg;
    logic [ppw_pkg::OFF_W-1:0] off_reg;
    logic                      last_in_reg;
    logic                      last_t_reg;
    logic [ppw_pkg::OUT_W-1:0] phrase_count_reg, phrase_count_next;
    logic                      anchor_overflow_reg, anchor_overflow_next;

    // RAM ports
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [ppw_pkg::POS_W-1:0] mem_wdata;
    logic [AW-1:0]             mem_raddr;
    logic [ppw_pkg::POS_W-1:0] mem_rdata;

    ppw_pkg::cmp_t             cmp;

    logic                      in_fire;
    logic                      term_start;
    logic [CW-1:0]             cnt_base;
    logic                      ovf_base;
    logic [CW-1:0]             rd_base;
    logic [CW-1:0]             kept_base;
    logic [CW-1:0]             ri_inc;
    logic                      hit;
    logic [CW+ppw_pkg::OUT_W-1:0] cnt_ext;

    ppw_anchor_ram #(
        .DEPTH (MAX_ANCHORS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ppw_match_unit u_match (
        .anchor (mem_rdata),
        .offset (off_reg),
        .target (pos_reg),
        .result (cmp)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    // a word opens a new term when none is open or the command changes
    assign term_start = !term_open_reg || (open_cmd_reg != command);
    assign cnt_base   = (term_start && command == ppw_pkg::CMD_FIRST) ? '0 : anchor_count_reg;
    assign ovf_base   = (term_start && command == ppw_pkg::CMD_FIRST) ? 1'b0 : overflow_reg;
    assign rd_base    = (term_start && command == ppw_pkg::CMD_LATER) ? '0 : read_index_reg;
    assign kept_base  = (term_start && command == ppw_pkg::CMD_LATER) ? '0 : kept_count_reg;

    assign ri_inc  = read_index_reg + 1'b1;
    assign hit     = (read_index_reg < anchor_count_reg);
    assign cnt_ext = {{ppw_pkg::OUT_W{1'b0}}, anchor_count_reg};

    always_comb
    begin
        state_next           = state_reg;
        anchor_count_next    = anchor_count_reg;
        read_index_next      = read_index_reg;
        kept_count_next      = kept_count_reg;
        overflow_next        = overflow_reg;
        term_open_next       = term_open_reg;
        open_cmd_next        = open_cmd_reg;
        phase_next           = phase_reg;
        out_valid_next       = out_valid_reg && !out_ready;
        phrase_count_next    = phrase_count_reg;
        anchor_overflow_next = anchor_overflow_reg;
        mem_we               = 1'b0;
        mem_waddr            = kept_count_reg[AW-1:0];
        mem_wdata            = mem_rdata;
        mem_raddr            = ri_inc[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                // prefetch the first anchor the walk will look at
                mem_raddr = rd_base[AW-1:0];
                if (in_fire)
                begin
                    term_open_next = !last_in_term;
                    open_cmd_next  = command;
                    if (command == ppw_pkg::CMD_FIRST)
                    begin
                        anchor_count_next = cnt_base;
                        overflow_next     = ovf_base;
                        if (position >= {{(ppw_pkg::POS_W - ppw_pkg::OFF_W){1'b0}}, term_offset})
                        begin
                            if (cnt_base < CW'(MAX_ANCHORS))
                            begin
                                mem_we            = 1'b1;
                                mem_waddr         = cnt_base[AW-1:0];
                                mem_wdata         = position -
                                    {{(ppw_pkg::POS_W - ppw_pkg::OFF_W){1'b0}}, term_offset};
                                anchor_count_next = cnt_base + 1'b1;
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                            end
                        end
                        if (last_in_term && last_term)
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                    else
                    begin
                        read_index_next = rd_base;
                        kept_count_next = kept_base;
                        phase_next      = 1'b0;
                        state_next      = ST_WALK;
                    end
                end
            end

            ST_WALK:
            begin
                if (hit && !phase_reg && cmp.lt)
                begin
                    read_index_next = ri_inc;
                end
                else if (hit && cmp.eq)
                begin
                    // compact in place; kept never passes the read index
                    mem_we          = 1'b1;
                    kept_count_next = kept_count_reg + 1'b1;
                    read_index_next = ri_inc;
                    phase_next      = 1'b1;
                end
                else
                begin
                    if (last_in_reg)
                    begin
                        anchor_count_next = kept_count_reg;
                    end
                    state_next = (last_in_reg && last_t_reg) ? ST_EMIT : ST_IDLE;
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next       = 1'b1;
                    phrase_count_next    = cnt_ext[ppw_pkg::OUT_W-1:0];
                    anchor_overflow_next = overflow_reg;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            anchor_count_reg <= '0;
            read_index_reg   <= '0;
            kept_count_reg   <= '0;
            overflow_reg     <= 1'b0;
            term_open_reg    <= 1'b0;
            open_cmd_reg     <= ppw_pkg::CMD_FIRST;
            phase_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            anchor_count_reg <= anchor_count_next;
            read_index_reg   <= read_index_next;
            kept_count_reg   <= kept_count_next;
            overflow_reg     <= overflow_next;
            term_open_reg    <= term_open_next;
            open_cmd_reg     <= open_cmd_next;
            phase_reg        <= phase_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pos_reg     <= position;
            off_reg     <= term_offset;
            last_in_reg <= last_in_term;
            last_t_reg  <= last_term;
        end
        phrase_count_reg    <= phrase_count_next;
        anchor_overflow_reg <= anchor_overflow_next;
    end

    assign out_valid       = out_valid_reg;
    assign phrase_count    = phrase_count_reg;
    assign anchor_overflow = anchor_overflow_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // compaction never writes ahead of the read pointer
    a_kept_behind: assert property (@(posedge clk) disable iff (!rst_n)
        kept_count_reg <= read_index_reg)
        else $error("kept count passed read index");

    // the store never reports more anchors than it holds
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        anchor_count_reg <= CW'(MAX_ANCHORS))
        else $error("anchor count beyond capacity");

    // during a walk the read pointer never passes the anchor count
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (read_index_reg <= anchor_count_reg))
        else $error("walk read index beyond anchor count");

    // a result register is only loaded from the emit step
    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_EMIT))
        else $error("result raised outside emit step");

endmodule

/* src/ppw_anchor_ram.sv */
// ----------------------------------------------------------------------------
// ppw_anchor_ram
// Anchor store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ppw_anchor_ram #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [AW-1:0]                 waddr,
    input  logic [ppw_pkg::POS_W-1:0]     wdata,
    input  logic [AW-1:0]                 raddr,
    output logic [ppw_pkg::POS_W-1:0]     rdata
);

    logic [ppw_pkg::POS_W-1:0] mem [DEPTH];
    logic [ppw_pkg::POS_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/ppw_match_unit.sv */
// ----------------------------------------------------------------------------
// ppw_match_unit
// Shared adder/comparator: anchor + offset against the current position.
// ----------------------------------------------------------------------------
module ppw_match_unit (
    input  logic [ppw_pkg::POS_W-1:0] anchor,
    input  logic [ppw_pkg::OFF_W-1:0] offset,
    input  logic [ppw_pkg::POS_W-1:0] target,
    output ppw_pkg::cmp_t             result
);

    logic [ppw_pkg::POS_W:0] sum;
    logic [ppw_pkg::POS_W:0] tgt;

    // one bit of headroom so the sum never wraps
    assign sum = {1'b0, anchor} + {{(ppw_pkg::POS_W + 1 - ppw_pkg::OFF_W){1'b0}}, offset};
    assign tgt = {1'b0, target};

    assign result.lt = (sum < tgt);
    assign result.eq = (sum == tgt);

endmodule
